// ----- rtl/cpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpm_pkg
// Types and constants for the cooling performance monitor.
// ----------------------------------------------------------------------------
package cpm_pkg;

    localparam int TEMP_SLOTS = 4;
    localparam int SLOT_IDX_W = $clog2(TEMP_SLOTS);
    localparam int CNT_W      = $clog2(TEMP_SLOTS + 1);
    localparam int TEMP_W     = 12;
    localparam int LEN_W      = 32;
    localparam int GAP_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GAP          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DROP           = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RESET_DELTA = 2'd3;

    // Register reset values
    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET      = 32'd1800000;
    localparam logic [GAP_W-1:0] START_GAP_RESET          = 11'd32;
    localparam logic [GAP_W-1:0] MIN_DROP_RESET           = 11'd8;
    localparam logic [GAP_W-1:0] TARGET_RESET_DELTA_RESET = 11'd8;

    // -100 degC in 1/16 degC
    localparam logic signed [TEMP_W-1:0] TEMP_RESET_VALUE = -12'sd1600;

    typedef struct packed {
        logic [31:0]             now_ms;
        logic                    cooler_on;
        logic                    cooler_available;
        logic signed [11:0]      temp_slot0;
        logic signed [11:0]      temp_slot1;
        logic signed [11:0]      temp_slot2;
        logic signed [11:0]      temp_slot3;
        logic [TEMP_SLOTS-1:0]   slot_valid_mask;
        logic signed [11:0]      setpoint;
    } tick_t;

    typedef struct packed {
        logic warning;
        logic warning_changed;
        logic monitoring;
    } status_t;

endpackage

// ----- rtl/cooling_performance_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooling_performance_monitor
// Averages valid temperature slots and tracks cooling progress per window.
//
//   channel   dir   signals                         notes
//   tick      in    tick_valid/tick_ready/tick      one monitor tick per item
//   status    out   status_valid/status_ready/status one result per item
//   cfg       in    cfg_we/cfg_index/cfg_wdata      register write, no wait
//
// The divide is skipped when no slot is valid. The slot sum, the magnitude
// and sign fix steps and the 14-step restoring divide run on one shared adder.
// tick_ready is high only while the sequencer is idle. A result waiting on
// status_ready holds the sequencer in its last step.
// Reset clears the sequencer, monitor state and registers to their defaults.
// ----------------------------------------------------------------------------
module cooling_performance_monitor
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    output logic                                tick_ready,
    input  cpm_pkg::tick_t                      tick,
    output logic                                status_valid,
    input  logic                                status_ready,
    output cpm_pkg::status_t                    status,
    input  logic                                cfg_we,
    input  logic [cpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int ALU_W = 15;
    localparam int ACC_W = 14;
    localparam int DIV_STEPS = ACC_W;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_MAG  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIX  = 3'd4;
    localparam logic [2:0] ST_EVAL = 3'd5;
    localparam logic [2:0] ST_UPD  = 3'd6;

    // Configuration
    logic [cpm_pkg::LEN_W-1:0] window_length_reg;
    logic [cpm_pkg::GAP_W-1:0] start_gap_reg;
    logic [cpm_pkg::GAP_W-1:0] min_drop_reg;
    logic [cpm_pkg::GAP_W-1:0] target_reset_delta_reg;

    // Sequencer and datapath
    logic [2:0]                         state_reg, state_next;
    cpm_pkg::tick_t                     item_reg, item_next;
    logic [cpm_pkg::SLOT_IDX_W-1:0]     idx_reg, idx_next;
    logic [cpm_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [ACC_W-1:0]            acc_reg, acc_next;
    logic [ACC_W-1:0]                   mag_reg, mag_next;
    logic [1:0]                         rem_reg, rem_next;
    logic [DCNT_W-1:0]                  dcnt_reg, dcnt_next;
    logic signed [cpm_pkg::TEMP_W-1:0]  avg_reg, avg_next;

    logic should_reg, should_next;
    logic moved_reg, moved_next;
    logic elapsed_reg, elapsed_next;
    logic drop_low_reg, drop_low_next;

    // Monitor state
    logic                               active_reg, active_next;
    logic [31:0]                        wstart_ms_reg, wstart_ms_next;
    logic signed [cpm_pkg::TEMP_W-1:0]  wstart_temp_reg, wstart_temp_next;
    logic signed [cpm_pkg::TEMP_W-1:0]  snap_reg, snap_next;
    logic                               warning_reg, warning_next;

    // Output
    logic               status_valid_reg, status_valid_next;
    cpm_pkg::status_t   status_reg, status_next;

    // Shared adder
    logic signed [ALU_W-1:0] alu_a, alu_b, alu_y;
    logic                    alu_sub;

    logic signed [cpm_pkg::TEMP_W-1:0] slots [cpm_pkg::TEMP_SLOTS];
    logic signed [cpm_pkg::TEMP_W-1:0] slot_sel;
    logic                              slot_ok;
    logic [2:0]                        trial;
    logic                              neg;
    logic                              out_free;

    // Evaluation terms
    logic signed [13:0] thr;
    logic signed [12:0] tdiff;
    logic [12:0]        tdiff_abs;
    logic [31:0]        elapsed;
    logic signed [12:0] drop;

    assign slots[0] = item_reg.temp_slot0;
    assign slots[1] = item_reg.temp_slot1;
    assign slots[2] = item_reg.temp_slot2;
    assign slots[3] = item_reg.temp_slot3;
    assign slot_sel = slots[idx_reg];
    assign slot_ok  = item_reg.slot_valid_mask[idx_reg];
    assign trial    = {rem_reg, mag_reg[ACC_W-1]};
    assign neg      = acc_reg[ACC_W-1];
    assign out_free = !status_valid_reg || status_ready;

    assign tick_ready   = (state_reg == ST_IDLE);
    assign status_valid = status_valid_reg;
    assign status       = status_reg;

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_SUM:
            begin
                alu_a = ALU_W'(acc_reg);
                alu_b = slot_ok ? ALU_W'(slot_sel) : '0;
            end
            ST_MAG:
            begin
                alu_b   = ALU_W'(acc_reg);
                alu_sub = neg;
            end
            ST_DIV:
            begin
                alu_a   = $signed({{(ALU_W-3){1'b0}}, trial});
                alu_b   = $signed({{(ALU_W-cpm_pkg::CNT_W){1'b0}}, cnt_reg});
                alu_sub = 1'b1;
            end
            ST_FIX:
            begin
                alu_a = neg ? ~$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
                alu_b = (neg && rem_reg == 2'd0) ? ALU_W'(1) : '0;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    always_comb
    begin
        thr       = 14'(item_reg.setpoint) + $signed({3'b0, start_gap_reg});
        tdiff     = 13'(item_reg.setpoint) - 13'(snap_reg);
        tdiff_abs = tdiff[12] ? 13'(-tdiff) : 13'(tdiff);
        elapsed   = item_reg.now_ms - wstart_ms_reg;
        drop      = 13'(wstart_temp_reg) - 13'(avg_reg);
    end

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        acc_next          = acc_reg;
        mag_next          = mag_reg;
        rem_next          = rem_reg;
        dcnt_next         = dcnt_reg;
        avg_next          = avg_reg;
        should_next       = should_reg;
        moved_next        = moved_reg;
        elapsed_next      = elapsed_reg;
        drop_low_next     = drop_low_reg;
        active_next       = active_reg;
        wstart_ms_next    = wstart_ms_reg;
        wstart_temp_next  = wstart_temp_reg;
        snap_next         = snap_reg;
        warning_next      = warning_reg;
        status_next       = status_reg;
        status_valid_next = status_valid_reg && !status_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    item_next  = tick;
                    idx_next   = '0;
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                acc_next = alu_y[ACC_W-1:0];
                cnt_next = cnt_reg + cpm_pkg::CNT_W'(slot_ok);
                idx_next = idx_reg + cpm_pkg::SLOT_IDX_W'(1);
                if (idx_reg == cpm_pkg::SLOT_IDX_W'(cpm_pkg::TEMP_SLOTS - 1))
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                mag_next  = alu_y[ACC_W-1:0];
                rem_next  = '0;
                dcnt_next = '0;
                avg_next  = cpm_pkg::TEMP_RESET_VALUE;
                state_next = (cnt_reg == '0) ? ST_EVAL : ST_DIV;
            end
            ST_DIV:
            begin
                if (!alu_y[ALU_W-1])
                begin
                    rem_next = alu_y[1:0];
                    mag_next = {mag_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[1:0];
                    mag_next = {mag_reg[ACC_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                avg_next   = alu_y[cpm_pkg::TEMP_W-1:0];
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                should_next   = item_reg.cooler_on && item_reg.cooler_available
                                && (cnt_reg != '0) && (14'(avg_reg) >= thr);
                moved_next    = tdiff_abs >= {2'b0, target_reset_delta_reg};
                elapsed_next  = elapsed >= window_length_reg;
                drop_low_next = drop < $signed({2'b0, min_drop_reg});
                state_next    = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    if (!should_reg || moved_reg)
                    begin
                        active_next      = 1'b0;
                        wstart_ms_next   = '0;
                        wstart_temp_next = cpm_pkg::TEMP_RESET_VALUE;
                        snap_next        = item_reg.setpoint;
                        warning_next     = 1'b0;
                    end
                    else if (!active_reg)
                    begin
                        active_next      = 1'b1;
                        wstart_ms_next   = item_reg.now_ms;
                        wstart_temp_next = avg_reg;
                        snap_next        = item_reg.setpoint;
                    end
                    else if (elapsed_reg)
                    begin
                        warning_next     = drop_low_reg;
                        wstart_ms_next   = item_reg.now_ms;
                        wstart_temp_next = avg_reg;
                    end
                    status_next.warning         = warning_next;
                    status_next.warning_changed = warning_next != warning_reg;
                    status_next.monitoring      = active_next;
                    status_valid_next           = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            status_valid_reg <= 1'b0;
            active_reg       <= 1'b0;
            wstart_ms_reg    <= '0;
            wstart_temp_reg  <= cpm_pkg::TEMP_RESET_VALUE;
            snap_reg         <= '0;
            warning_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            status_valid_reg <= status_valid_next;
            active_reg       <= active_next;
            wstart_ms_reg    <= wstart_ms_next;
            wstart_temp_reg  <= wstart_temp_next;
            snap_reg         <= snap_next;
            warning_reg      <= warning_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg      <= cpm_pkg::WINDOW_LENGTH_RESET;
            start_gap_reg          <= cpm_pkg::START_GAP_RESET;
            min_drop_reg           <= cpm_pkg::MIN_DROP_RESET;
            target_reset_delta_reg <= cpm_pkg::TARGET_RESET_DELTA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpm_pkg::CFG_WINDOW_LENGTH:
                    window_length_reg <= cfg_wdata[cpm_pkg::LEN_W-1:0];
                cpm_pkg::CFG_START_GAP:
                    start_gap_reg <= cfg_wdata[cpm_pkg::GAP_W-1:0];
                cpm_pkg::CFG_MIN_DROP:
                    min_drop_reg <= cfg_wdata[cpm_pkg::GAP_W-1:0];
                cpm_pkg::CFG_TARGET_RESET_DELTA:
                    target_reset_delta_reg <= cfg_wdata[cpm_pkg::GAP_W-1:0];
                default:
                    window_length_reg <= window_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        avg_reg      <= avg_next;
        should_reg   <= should_next;
        moved_reg    <= moved_next;
        elapsed_reg  <= elapsed_next;
        drop_low_reg <= drop_low_next;
        status_reg   <= status_next;
    end

endmodule
